@@ hdl/bmp_blit_pkg.sv @@
// Shared constants and types for the BMP stream to framebuffer blit unit.
package bmp_blit_pkg;

   localparam int HEADER_BYTES     = 54;
   localparam int WIDTH_FIRST      = 18;
   localparam int WIDTH_LAST       = 21;
   localparam int HEIGHT_FIRST     = 22;
   localparam int HEIGHT_LAST      = 25;

   localparam int SCREEN_WIDTH_DEF  = 800;
   localparam int SCREEN_HEIGHT_DEF = 480;

   localparam int BYTE_W      = 8;
   localparam int HDR_CNT_W   = 6;
   localparam int DIM_W       = 32;
   localparam int OFFSET_W    = 12;
   localparam int COORD_W     = 12;
   localparam int ADDR_W      = 19;
   localparam int COLOR_W     = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_X = 1'b0,
      CSR_OFFSET_Y = 1'b1
   } csr_index_type;

   // Pixel captured on its red byte, before placement on the screen
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [DIM_W-1:0]   column;
      logic [DIM_W-1:0]   rows_left;
   } pixel_type;

   // Pixel known to be on screen, with its screen coordinates
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } placed_type;

endpackage

@@ hdl/bmp_blit_if.sv @@
// Channel interfaces for the BMP stream to framebuffer blit unit.
interface bmp_blit_req_if;
   logic                              valid;
   logic                              ready;
   logic [bmp_blit_pkg::BYTE_W-1:0]   data_byte;
   logic                              new_file;

   modport source (output valid, data_byte, new_file, input ready);
   modport sink   (input valid, data_byte, new_file, output ready);
endinterface

interface bmp_blit_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bmp_blit_pkg::ADDR_W-1:0]   fb_address;
   logic [bmp_blit_pkg::COLOR_W-1:0]  pixel_color;

   modport source (output valid, fb_address, pixel_color, input ready);
   modport sink   (input valid, fb_address, pixel_color, output ready);
endinterface

interface bmp_blit_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [bmp_blit_pkg::CSR_INDEX_W-1:0] index;
   logic [bmp_blit_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/bmp_stream_to_framebuffer_blit_unit.sv @@
// A pixel passes from the transfer of its red byte through the capture, placement
// check and address multiply registers, in that order, before it leaves.
// Throughput: one file byte per cycle; req ready falls only while the output
// register holds a result that is not taken and the stages behind it are full.
// Reset (synchronous): offsets go to zero, pipeline empties, and bytes are
// dropped until a transfer with new_file set starts a file.
module bmp_stream_to_framebuffer_blit_unit #(
   parameter int SCREEN_WIDTH  = bmp_blit_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = bmp_blit_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bmp_blit_req_if.sink      req_ch,
   bmp_blit_rsp_if.source    rsp_ch,
   bmp_blit_csr_if.sink      csr_ch
);

   localparam int DW = bmp_blit_pkg::DIM_W;
   localparam int CW = bmp_blit_pkg::COORD_W;
   localparam int OW = bmp_blit_pkg::OFFSET_W;
   localparam int SW = DW + 2;
   localparam int PW = 2 * CW + 1;
   localparam logic signed [SW-1:0] ScreenHeightS = SW'(SCREEN_HEIGHT);
   localparam logic signed [SW-1:0] ScreenWidthS  = SW'(SCREEN_WIDTH);
   localparam logic [PW-1:0]        ScreenWidthP  = PW'(SCREEN_WIDTH);
   localparam logic [bmp_blit_pkg::HDR_CNT_W-1:0] HdrEnd =
      bmp_blit_pkg::HDR_CNT_W'(bmp_blit_pkg::HEADER_BYTES);
   localparam logic [bmp_blit_pkg::HDR_CNT_W-1:0] HdrLast =
      bmp_blit_pkg::HDR_CNT_W'(bmp_blit_pkg::HEADER_BYTES - 1);

   typedef enum logic [1:0] {
      PH_BLUE,
      PH_GREEN,
      PH_RED
   } phase_type;

   // configuration
   logic signed [OW-1:0] offset_x_ff, offset_y_ff;

   // parse state
   logic [bmp_blit_pkg::HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [DW-1:0]  width_ff, width_in;
   logic [DW-1:0]  height_ff, height_in;
   logic [DW-1:0]  column_ff, column_in;
   logic [DW-1:0]  rows_left_ff, rows_left_in;
   phase_type      phase_ff, phase_in;
   logic [15:0]    partial_ff, partial_in;
   logic           done_ff, done_in;

   // pipeline
   logic                      s1_v_ff, s1_v_in;
   bmp_blit_pkg::pixel_type   s1_ff, s1_in;
   logic                      s2_v_ff, s2_v_in;
   bmp_blit_pkg::placed_type  s2_ff, s2_in;
   logic                      out_v_ff, out_v_in;
   logic [bmp_blit_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [bmp_blit_pkg::COLOR_W-1:0] color_ff, color_in;

   logic req_fire, s1_adv, s2_adv, s1_push;
   logic [bmp_blit_pkg::HDR_CNT_W-1:0] hdr_eff;
   logic done_eff, hdr_bad;
   logic signed [SW-1:0] scr_row, scr_col;
   logic on_screen;
   logic [PW-1:0] addr_full;

   // handshake chain: each stage moves when the one ahead is empty or moving
   assign s2_adv       = !out_v_ff || rsp_ch.ready;
   assign s1_adv       = !s2_v_ff || s2_adv;
   assign req_ch.ready = !s1_v_ff || s1_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // byte parser
   assign hdr_eff  = req_ch.new_file ? '0 : hdr_cnt_ff;
   assign done_eff = req_ch.new_file ? 1'b0 : done_ff;
   assign hdr_bad  = width_ff[DW-1] || (width_ff == '0) ||
                     height_ff[DW-1] || (height_ff == '0);

   always_comb begin
      hdr_cnt_in   = hdr_cnt_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      column_in    = column_ff;
      rows_left_in = rows_left_ff;
      phase_in     = phase_ff;
      partial_in   = partial_ff;
      done_in      = done_ff;
      s1_push      = 1'b0;
      s1_in        = s1_ff;
      if (req_fire) begin
         hdr_cnt_in = hdr_eff;
         done_in    = done_eff;
         if (req_ch.new_file) begin
            width_in  = '0;
            height_in = '0;
         end
         if (!done_eff) begin
            if (hdr_eff != HdrEnd) begin
               if (hdr_eff >= bmp_blit_pkg::HDR_CNT_W'(bmp_blit_pkg::WIDTH_FIRST) &&
                   hdr_eff <= bmp_blit_pkg::HDR_CNT_W'(bmp_blit_pkg::WIDTH_LAST)) begin
                  width_in = {req_ch.data_byte, width_ff[DW-1:8]};
               end else if (hdr_eff >= bmp_blit_pkg::HDR_CNT_W'(bmp_blit_pkg::HEIGHT_FIRST) &&
                            hdr_eff <= bmp_blit_pkg::HDR_CNT_W'(bmp_blit_pkg::HEIGHT_LAST)) begin
                  height_in = {req_ch.data_byte, height_ff[DW-1:8]};
               end
               hdr_cnt_in = hdr_eff + 1'b1;
               if (hdr_eff == HdrLast) begin
                  done_in      = hdr_bad;
                  column_in    = '0;
                  rows_left_in = height_ff - 1'b1;
                  phase_in     = PH_BLUE;
               end
            end else begin
               unique case (phase_ff)
                  PH_BLUE: begin
                     partial_in = {8'h00, req_ch.data_byte};
                     phase_in   = PH_GREEN;
                  end
                  PH_GREEN: begin
                     partial_in = {req_ch.data_byte, partial_ff[7:0]};
                     phase_in   = PH_RED;
                  end
                  default: begin
                     s1_push         = 1'b1;
                     s1_in.color     = {req_ch.data_byte, partial_ff};
                     s1_in.column    = column_ff;
                     s1_in.rows_left = rows_left_ff;
                     partial_in      = '0;
                     phase_in        = PH_BLUE;
                     // advance column; wrap into the next row up the screen
                     if (column_ff + 1'b1 == width_ff) begin
                        column_in = '0;
                        if (rows_left_ff == '0) begin
                           done_in = 1'b1;
                        end else begin
                           rows_left_in = rows_left_ff - 1'b1;
                        end
                     end else begin
                        column_in = column_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
      end
   end

   // placement check
   assign scr_row   = $signed({2'b00, s1_ff.rows_left}) + SW'(offset_y_ff);
   assign scr_col   = $signed({2'b00, s1_ff.column}) + SW'(offset_x_ff);
   assign on_screen = !scr_row[SW-1] && (scr_row < ScreenHeightS) &&
                      !scr_col[SW-1] && (scr_col < ScreenWidthS);

   always_comb begin
      s1_v_in = s1_v_ff;
      if (s1_adv) begin
         s1_v_in = 1'b0;
      end
      if (s1_push) begin
         s1_v_in = 1'b1;
      end
      s2_v_in = s2_v_ff;
      s2_in   = s2_ff;
      if (s1_adv) begin
         s2_v_in     = s1_v_ff && on_screen;
         s2_in.color = s1_ff.color;
         s2_in.row   = scr_row[CW-1:0];
         s2_in.col   = scr_col[CW-1:0];
      end
   end

   // address: row * screen width + column, low bits kept
   assign addr_full = PW'(s2_ff.row) * ScreenWidthP + PW'(s2_ff.col);

   always_comb begin
      out_v_in = out_v_ff;
      addr_in  = addr_ff;
      color_in = color_ff;
      if (s2_adv) begin
         out_v_in = s2_v_ff;
         addr_in  = addr_full[bmp_blit_pkg::ADDR_W-1:0];
         color_in = s2_ff.color;
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.fb_address  = addr_ff;
   assign rsp_ch.pixel_color = color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         hdr_cnt_ff   <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         column_ff    <= '0;
         rows_left_ff <= '0;
         phase_ff     <= PH_BLUE;
         done_ff      <= 1'b1;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               bmp_blit_pkg::CSR_OFFSET_X: offset_x_ff <= $signed(csr_ch.data[OW-1:0]);
               bmp_blit_pkg::CSR_OFFSET_Y: offset_y_ff <= $signed(csr_ch.data[OW-1:0]);
               default: ;
            endcase
         end
         hdr_cnt_ff   <= hdr_cnt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         column_ff    <= column_in;
         rows_left_ff <= rows_left_in;
         phase_ff     <= phase_in;
         done_ff      <= done_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         out_v_ff     <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      partial_ff <= partial_in;
      s1_ff      <= s1_in;
      s2_ff      <= s2_in;
      addr_ff    <= addr_in;
      color_ff   <= color_in;
   end

   a_hdr_bound: assert property (@(posedge clock) disable iff (reset)
      hdr_cnt_ff <= HdrEnd)
      else $error("header count past end of header");

   a_new_file_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.new_file) |=> (!done_ff && hdr_cnt_ff == 1))
      else $error("new file did not restart parsing");

   a_placed_on_screen: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> (32'(s2_ff.row) < 32'(SCREEN_HEIGHT) &&
                   32'(s2_ff.col) < 32'(SCREEN_WIDTH)))
      else $error("off-screen pixel reached the address stage");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("input stalled without output backpressure");

   a_red_push: assert property (@(posedge clock) disable iff (reset)
      s1_push |=> (s1_v_ff && phase_ff == PH_BLUE))
      else $error("captured pixel lost or phase not rewound");

endmodule
